// ----- sv/kwt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kwt_pkg;

  localparam int KEYWORD_CHARS = 9;
  localparam int POSITION_BITS = 16;
  localparam int LEN_BITS      = 16;
  localparam int PREFIX_IDX_W  = $clog2(KEYWORD_CHARS);
  localparam int NUM_KEYWORDS  = 18;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [LEN_BITS-1:0]      LEN_MAX = '1;

  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_NUMBER  = 5'd2;
  localparam logic [4:0] K_STRING  = 5'd3;
  localparam logic [4:0] K_ASSIGN  = 5'd4;
  localparam logic [4:0] K_OP      = 5'd5;
  localparam logic [4:0] K_LPAREN  = 5'd6;
  localparam logic [4:0] K_RPAREN  = 5'd7;
  localparam logic [4:0] K_COLON   = 5'd8;
  localparam logic [4:0] K_COMMA   = 5'd9;
  localparam logic [4:0] K_UNKNOWN = 5'd10;
  localparam logic [4:0] K_KW0     = 5'd11;

  // right-justified text: the last character sits in bits [7:0]
  localparam logic [71:0] KW_TEXT [NUM_KEYWORDS] = '{
    72'("INPUT"), 72'("OUTPUT"), 72'("TRUE"), 72'("FALSE"), 72'("IF"), 72'("THEN"),
    72'("ELSE"), 72'("ENDIF"), 72'("FOR"), 72'("TO"), 72'("NEXT"), 72'("WHILE"),
    72'("ENDWHILE"), 72'("REPEAT"), 72'("UNTIL"), 72'("PROCEDURE"), 72'("FUNCTION"),
    72'("RETURN")
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd5, 4'd6, 4'd4, 4'd5, 4'd2, 4'd4, 4'd4, 4'd5, 4'd3,
    4'd2, 4'd4, 4'd5, 4'd8, 4'd6, 4'd5, 4'd9, 4'd8, 4'd6
  };

  typedef struct packed {
    logic [4:0]          kind;
    logic [15:0]         start;
    logic [LEN_BITS-1:0] length;
    logic                last;
    logic                ovf;
  } tok_t;

  // all keyword compares run side by side; spellings are distinct so at most one hits
  function automatic logic [4:0] word_kind(input logic [KEYWORD_CHARS-1:0][7:0] prefix,
                                           input logic [LEN_BITS-1:0] len);
    logic [4:0] kind;
    logic       hit;
    int         kl;
    kind = K_IDENT;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      kl  = int'(KW_LEN[k]);
      hit = (len == LEN_BITS'(kl));
      for (int i = 0; i < 9; i++) begin
        if (i < kl) begin
          if (prefix[i] != KW_TEXT[k][8*(kl-1-i) +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        kind = K_KW0 + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

// ----- sv/kwt_token_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kwt_token_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_count,
  input  wire kwt_pkg::tok_t     push0,
  input  wire kwt_pkg::tok_t     push1,
  input  wire logic              pop,
  output logic                   room_for_two,
  output logic                   head_valid,
  output kwt_pkg::tok_t          head
);

  kwt_pkg::tok_t                     mem [kwt_pkg::FIFO_DEPTH];
  logic [kwt_pkg::FIFO_PTR_W-1:0]    wr_ptr;
  logic [kwt_pkg::FIFO_PTR_W-1:0]    rd_ptr;
  logic [kwt_pkg::FIFO_PTR_W:0]      count;
  logic [kwt_pkg::FIFO_PTR_W:0]      count_next;
  logic [kwt_pkg::FIFO_PTR_W-1:0]    wr_ptr_p1;

  assign wr_ptr_p1    = wr_ptr + 1'b1;
  assign head_valid   = (count != '0);
  assign head         = mem[rd_ptr];
  assign room_for_two = (count <= (kwt_pkg::FIFO_PTR_W + 1)'(kwt_pkg::FIFO_DEPTH - 2));

  always_comb begin
    count_next = count + (kwt_pkg::FIFO_PTR_W + 1)'(push_count)
                 - (kwt_pkg::FIFO_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + kwt_pkg::FIFO_PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/keyword_token_lexer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// in        to block   in_valid / in_stall   op, text_byte
// out       from block out_valid / out_stall token_kind, token_start, token_length,
//                                            last_of_run, position_overflow
//
// One text byte is taken per cycle while in_stall is low; scan state updates in
// the cycle it is taken. Its zero to two tokens enter a four-entry token queue
// and leave one per cycle while out_stall is low; a byte's two tokens leave in order.
// in_stall rises while the queue has fewer than two free entries.
// Synchronous reset clears scan state and the queue; no clearing pass is needed.

module keyword_token_lexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  text_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic             last_of_run,
  output logic             position_overflow
);

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_WORD = 6'b000010,
    MODE_NUM  = 6'b000100,
    MODE_STR  = 6'b001000,
    MODE_LT   = 6'b010000,
    MODE_GT   = 6'b100000
  } mode_t;

  mode_t                                         mode, mode_next;
  logic [kwt_pkg::POSITION_BITS-1:0]             pos, pos_next;
  logic [kwt_pkg::POSITION_BITS-1:0]             pend_start, pend_start_next;
  logic [kwt_pkg::LEN_BITS-1:0]                  pend_len, pend_len_next;
  logic [kwt_pkg::KEYWORD_CHARS-1:0][7:0]        word_prefix, word_prefix_next;
  logic                                          ovf, ovf_next;

  logic          accept;
  logic          room_for_two;
  logic          head_valid;
  logic          pop;
  logic [1:0]    push_count;
  kwt_pkg::tok_t push0, push1, head;

  logic          is_alpha, is_digit, is_space, is_word;
  logic [kwt_pkg::LEN_BITS-1:0] len_grown;

  kwt_pkg::tok_t fl_tok, st_tok, e0, e1;
  logic          fl_v, st_v, e0_v, e1_v;
  mode_t         st_mode;
  logic [kwt_pkg::POSITION_BITS-1:0] st_start;
  logic [kwt_pkg::LEN_BITS-1:0]      st_len;
  logic          flag;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = !room_for_two;
  assign pop       = head_valid && !out_stall;
  assign out_valid = head_valid;

  assign token_kind        = head.kind;
  assign token_start       = head.start;
  assign token_length      = head.length;
  assign last_of_run       = head.last;
  assign position_overflow = head.ovf;

  assign is_alpha  = (text_byte >= "A" && text_byte <= "Z") ||
                     (text_byte >= "a" && text_byte <= "z");
  assign is_digit  = (text_byte >= "0" && text_byte <= "9");
  assign is_space  = (text_byte == " ") || (text_byte >= 8'd9 && text_byte <= 8'd13);
  assign is_word   = is_alpha || is_digit || (text_byte == "_");
  assign len_grown = (pend_len < kwt_pkg::LEN_MAX) ? pend_len + 1'b1 : pend_len;

  // token held by the current mode, as emitted when it is cut short
  always_comb begin
    fl_v        = 1'b1;
    fl_tok      = '0;
    fl_tok.start  = 16'(pend_start);
    fl_tok.length = pend_len;
    unique case (mode) inside
      MODE_WORD: fl_tok.kind = kwt_pkg::word_kind(word_prefix, pend_len);
      MODE_NUM:  fl_tok.kind = kwt_pkg::K_NUMBER;
      MODE_STR:  fl_tok.kind = kwt_pkg::K_STRING;
      MODE_LT, MODE_GT: begin
        fl_tok.kind   = kwt_pkg::K_OP;
        fl_tok.length = kwt_pkg::LEN_BITS'(1);
      end
      default: fl_v = 1'b0;
    endcase
  end

  // what the current byte does when it begins a new token
  always_comb begin
    st_v          = 1'b0;
    st_tok        = '0;
    st_tok.start  = 16'(pos);
    st_tok.length = kwt_pkg::LEN_BITS'(1);
    st_mode       = MODE_IDLE;
    st_start      = pos;
    st_len        = kwt_pkg::LEN_BITS'(1);
    if (is_space) begin
      st_mode = MODE_IDLE;
    end else if (is_alpha) begin
      st_mode = MODE_WORD;
    end else if (is_digit) begin
      st_mode = MODE_NUM;
    end else if (text_byte == "\"") begin
      st_mode  = MODE_STR;
      st_start = (pos < kwt_pkg::POS_MAX) ? pos + 1'b1 : kwt_pkg::POS_MAX;
      st_len   = '0;
    end else if (text_byte == "<") begin
      st_mode = MODE_LT;
    end else if (text_byte == ">") begin
      st_mode = MODE_GT;
    end else begin
      st_v = 1'b1;
      case (text_byte) inside
        "(":                     st_tok.kind = kwt_pkg::K_LPAREN;
        ")":                     st_tok.kind = kwt_pkg::K_RPAREN;
        ":":                     st_tok.kind = kwt_pkg::K_COLON;
        ",":                     st_tok.kind = kwt_pkg::K_COMMA;
        "+", "-", "*", "/", "=": st_tok.kind = kwt_pkg::K_OP;
        default:                 st_tok.kind = kwt_pkg::K_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    mode_next        = mode;
    pos_next         = pos;
    pend_start_next  = pend_start;
    pend_len_next    = pend_len;
    word_prefix_next = word_prefix;
    ovf_next         = ovf;
    e0_v             = 1'b0;
    e1_v             = 1'b0;
    e0               = fl_tok;
    e1               = st_tok;
    flag             = ovf;
    push_count       = 2'd0;
    push0            = '0;
    push1            = '0;

    if (accept) begin
      if (op) begin
        e0_v     = fl_v;
        e1_v     = 1'b1;
        e1       = '0;
        e1.kind  = kwt_pkg::K_END;
        e1.start = 16'(pos);
        flag             = ovf;
        mode_next        = MODE_IDLE;
        pos_next         = '0;
        pend_start_next  = '0;
        pend_len_next    = '0;
        ovf_next         = 1'b0;
      end else begin
        if (pos < kwt_pkg::POS_MAX) begin
          pos_next = pos + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
        flag = ovf_next;

        // a byte that breaks the held token: flush it, then start afresh
        if ((mode == MODE_WORD && !is_word) ||
            (mode == MODE_NUM && !is_digit) ||
            (mode == MODE_LT && text_byte != "-" && text_byte != "=" && text_byte != ">") ||
            (mode == MODE_GT && text_byte != "=") ||
            (mode == MODE_IDLE)) begin
          e0_v            = fl_v;
          e1_v            = st_v;
          mode_next       = st_mode;
          if (st_mode != MODE_IDLE) begin
            pend_start_next = st_start;
            pend_len_next   = st_len;
          end
          if (is_alpha) begin
            word_prefix_next[0] = text_byte;
          end
        end else begin
          unique case (mode) inside
            MODE_WORD: begin
              if (pend_len < kwt_pkg::LEN_BITS'(kwt_pkg::KEYWORD_CHARS)) begin
                word_prefix_next[pend_len[kwt_pkg::PREFIX_IDX_W-1:0]] = text_byte;
              end
              pend_len_next = len_grown;
            end
            MODE_NUM: pend_len_next = len_grown;
            MODE_STR: begin
              if (text_byte == "\"") begin
                e0_v      = 1'b1;
                mode_next = MODE_IDLE;
              end else begin
                pend_len_next = len_grown;
              end
            end
            MODE_LT, MODE_GT: begin
              e0_v        = 1'b1;
              e0.kind     = (mode == MODE_LT && text_byte == "-") ? kwt_pkg::K_ASSIGN
                                                                  : kwt_pkg::K_OP;
              e0.length   = kwt_pkg::LEN_BITS'(2);
              mode_next   = MODE_IDLE;
            end
            default: mode_next = MODE_IDLE;
          endcase
        end
      end

      // pack emitted tokens toward slot 0 and mark the final one
      e0.ovf = flag;
      e1.ovf = flag;
      if (e0_v && e1_v) begin
        push_count = 2'd2;
        push0      = e0;
        push1      = e1;
        push1.last = 1'b1;
      end else if (e0_v) begin
        push_count = 2'd1;
        push0      = e0;
        push0.last = 1'b1;
      end else if (e1_v) begin
        push_count = 2'd1;
        push0      = e1;
        push0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      pos        <= '0;
      pend_start <= '0;
      pend_len   <= '0;
      ovf        <= 1'b0;
    end else begin
      mode       <= mode_next;
      pos        <= pos_next;
      pend_start <= pend_start_next;
      pend_len   <= pend_len_next;
      ovf        <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    word_prefix <= word_prefix_next;
  end

  kwt_token_fifo u_queue (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .push0        (push0),
    .push1        (push1),
    .pop          (pop),
    .room_for_two (room_for_two),
    .head_valid   (head_valid),
    .head         (head)
  );

endmodule

`default_nettype wire
